FILE: design/iefb_pkg.sv
// Shared types and constants for the ICMP echo request frame builder.
// No dependencies; imported by every module of the block.
`default_nettype none

package iefb_pkg;

  localparam int FRAME_LEN = 58;
  localparam int BYTE_CNT_W = $clog2(FRAME_LEN);
  localparam logic [BYTE_CNT_W-1:0] LAST_BYTE_IDX = BYTE_CNT_W'(FRAME_LEN - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEXT_HOP_MAC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP     = 2'd2;
  localparam int CFG_DATA_W = 48;

  // Fixed header words
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [15:0] IP_TOTAL_LEN   = 16'd44;
  localparam logic [7:0]  IP_TTL         = 8'd64;
  localparam logic [7:0]  IP_PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
  localparam logic [7:0]  ICMP_CODE      = 8'd0;
  // Sum of the constant IPv4 header words: 0x4500 + 0x002c + 0x4001
  localparam logic [15:0] IP_CONST_SUM   = {IP_VER_IHL, 8'h00} + IP_TOTAL_LEN
                                         + {IP_TTL, IP_PROTO_ICMP};
  localparam logic [15:0] ICMP_TYPE_WORD = {ICMP_ECHO_REQ, ICMP_CODE};

  typedef struct packed {
    logic [31:0] dest_ip;
    logic [15:0] echo_id;
    logic [15:0] sequence_number;
    logic [62:0] stamp_seconds;
    logic [19:0] stamp_micros;
  } req_t;

  typedef struct packed {
    req_t        req;
    logic [15:0] ip_csum;
    logic [15:0] icmp_csum;
  } desc_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: design/icmp_echo_request_frame_builder.sv
// Top level of the ICMP echo request frame builder: configuration registers,
// front end, descriptor queue and byte serializer. Depends on iefb_pkg.
//
// Usage:
//  - Configuration: cfg_we with cfg_index 0 (local MAC), 1 (next-hop MAC) or
//    2 (local IPv4 address) writes cfg_data; index 3 is ignored.
//    Write only while no frame is in flight. All three reset to zero.
//  - Input: an echo request item is taken at an edge with in_push high and
//    in_full low.
//  - Output: while out_empty is low, out_frame_byte/out_last_byte show the
//    oldest frame byte; out_pop takes it. Each item gives 58 bytes in wire
//    order, out_last_byte high on the final one.
//  - Path: when idle, the first byte of a frame appears once the taken item
//    has passed the checksum stage, the queue write and the output register.
//  - Throughput: one byte per cycle while out_pop stays high, set by the
//    byte-wide serializer. The front end holds up to two items and the
//    queue two more, so requests can be taken while a frame is sent.
//  - Stall: if out_pop stays low the output register holds its byte, the
//    serializer stops, the queue fills and in_full rises; nothing is lost.
//  - Reset (rst_n low, synchronous) empties every stage and clears the
//    configuration registers.
`default_nettype none

module icmp_echo_request_frame_builder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [31:0]                   in_dest_ip,
  input  wire logic [15:0]                   in_echo_id,
  input  wire logic [15:0]                   in_sequence_number,
  input  wire logic [62:0]                   in_stamp_seconds,
  input  wire logic [19:0]                   in_stamp_micros,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [7:0]                         out_frame_byte,
  output logic                               out_last_byte,
  input  wire logic                          cfg_we,
  input  wire logic [iefb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [iefb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import iefb_pkg::*;

  logic [47:0] local_mac_r;
  logic [47:0] next_hop_mac_r;
  logic [31:0] src_ip_r;

  req_t    req_in;
  desc_t   push_desc, head_desc;
  q_ctrl_t q_ctrl;
  q_stat_t q_stat;
  logic    out_valid;

  // Configuration registers; an index past the list writes nothing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mac_r    <= '0;
      next_hop_mac_r <= '0;
      src_ip_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOCAL_MAC:    local_mac_r    <= cfg_data;
        CFG_NEXT_HOP_MAC: next_hop_mac_r <= cfg_data;
        CFG_LOCAL_IP:     src_ip_r       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign req_in.dest_ip         = in_dest_ip;
  assign req_in.echo_id         = in_echo_id;
  assign req_in.sequence_number = in_sequence_number;
  assign req_in.stamp_seconds   = in_stamp_seconds;
  assign req_in.stamp_micros    = in_stamp_micros;

  // Checksum pipeline
  iefb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_push),
    .req_in   (req_in),
    .req_full (in_full),
    .src_ip   (src_ip_r),
    .q_full   (q_stat.full),
    .q_push   (q_ctrl.push),
    .q_desc   (push_desc)
  );

  // Decouples checksum work from byte output
  iefb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (q_ctrl),
    .wr_desc  (push_desc),
    .stat     (q_stat),
    .head_desc(head_desc)
  );

  // Serializer; pops the descriptor as its last byte is registered
  iefb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (q_stat.head_valid),
    .head_desc   (head_desc),
    .head_pop    (q_ctrl.pop),
    .local_mac   (local_mac_r),
    .next_hop_mac(next_hop_mac_r),
    .src_ip      (src_ip_r),
    .out_valid   (out_valid),
    .out_take    (out_pop),
    .out_byte    (out_frame_byte),
    .out_last    (out_last_byte)
  );

  assign out_empty = ~out_valid;

endmodule

`default_nettype wire

FILE: design/iefb_front.sv
// Front end: accepts echo requests and computes both Internet checksums
// in two pipeline stages. Depends on iefb_pkg.
`default_nettype none

module iefb_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           req_valid,
  input  wire iefb_pkg::req_t req_in,
  output logic                req_full,
  input  wire logic [31:0]    src_ip,
  input  wire logic           q_full,
  output logic                q_push,
  output iefb_pkg::desc_t     q_desc
);
  import iefb_pkg::*;

  function automatic logic [15:0] csum_fold(input logic [19:0] s);
    logic [16:0] t;
    logic [15:0] u;
    t = {1'b0, s[15:0]} + {13'b0, s[19:16]};
    u = t[15:0] + {15'b0, t[16]};
    return ~u;
  endfunction

  logic        a_valid_r, a_valid_nxt;
  req_t        a_req_r;
  logic        b_valid_r, b_valid_nxt;
  req_t        b_req_r;
  logic [18:0] b_ip_sum_r;
  logic [18:0] b_icmp_lo_r;
  logic [17:0] b_icmp_hi_r;

  logic adv_a, adv_b, b_free, a_free;
  logic [19:0] icmp_sum;

  assign adv_b  = b_valid_r & ~q_full;
  assign b_free = ~b_valid_r | adv_b;
  assign adv_a  = a_valid_r & b_free;
  assign a_free = ~a_valid_r | adv_a;
  assign req_full = ~a_free;

  assign a_valid_nxt = (req_valid & a_free) | (a_valid_r & ~adv_a);
  assign b_valid_nxt = adv_a | (b_valid_r & ~adv_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && a_free) begin
      a_req_r <= req_in;
    end
  end

  // Partial sums; the timestamp words are byte-swapped since they go out LSB first
  always_ff @(posedge clk) begin
    if (adv_a) begin
      b_req_r     <= a_req_r;
      b_ip_sum_r  <= {3'b0, IP_CONST_SUM} + {3'b0, src_ip[31:16]}
                   + {3'b0, src_ip[15:0]} + {3'b0, a_req_r.dest_ip[31:16]}
                   + {3'b0, a_req_r.dest_ip[15:0]};
      b_icmp_lo_r <= {3'b0, ICMP_TYPE_WORD} + {3'b0, a_req_r.echo_id}
                   + {3'b0, a_req_r.sequence_number}
                   + {3'b0, a_req_r.stamp_seconds[7:0], a_req_r.stamp_seconds[15:8]}
                   + {3'b0, a_req_r.stamp_seconds[23:16], a_req_r.stamp_seconds[31:24]};
      b_icmp_hi_r <= {2'b0, a_req_r.stamp_seconds[39:32], a_req_r.stamp_seconds[47:40]}
                   + {2'b0, a_req_r.stamp_seconds[55:48], 1'b0,
                      a_req_r.stamp_seconds[62:56]}
                   + {2'b0, a_req_r.stamp_micros[7:0], a_req_r.stamp_micros[15:8]}
                   + {2'b0, 4'b0, a_req_r.stamp_micros[19:16], 8'h00};
    end
  end

  assign icmp_sum = {1'b0, b_icmp_lo_r} + {2'b0, b_icmp_hi_r};

  assign q_push           = adv_b;
  assign q_desc.req       = b_req_r;
  assign q_desc.ip_csum   = csum_fold({1'b0, b_ip_sum_r});
  assign q_desc.icmp_csum = csum_fold(icmp_sum);

endmodule

`default_nettype wire

FILE: design/iefb_queue.sv
// Two-entry descriptor queue between the front end and the serializer.
// Depends on iefb_pkg.
`default_nettype none

module iefb_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire iefb_pkg::q_ctrl_t ctrl,
  input  wire iefb_pkg::desc_t wr_desc,
  output iefb_pkg::q_stat_t    stat,
  output iefb_pkg::desc_t      head_desc
);
  import iefb_pkg::*;

  desc_t                  mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   do_push, do_pop;

  assign stat.full       = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign stat.head_valid = (count_r != '0);
  assign do_push = ctrl.push & ~stat.full;
  assign do_pop  = ctrl.pop & stat.head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

  assign head_desc = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

FILE: design/iefb_back.sv
// Back end: walks the head descriptor byte by byte into an output register.
// Depends on iefb_pkg.
`default_nettype none

module iefb_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire iefb_pkg::desc_t head_desc,
  output logic                 head_pop,
  input  wire logic [47:0]     local_mac,
  input  wire logic [47:0]     next_hop_mac,
  input  wire logic [31:0]     src_ip,
  output logic                 out_valid,
  input  wire logic            out_take,
  output logic [7:0]           out_byte,
  output logic                 out_last
);
  import iefb_pkg::*;

  logic [BYTE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  valid_r, valid_nxt;
  logic [7:0]            byte_r;
  logic                  last_r;
  logic                  fire, at_last;
  logic [7:0]            sel;
  req_t                  rq;

  assign rq      = head_desc.req;
  assign at_last = (cnt_r == LAST_BYTE_IDX);
  assign fire    = head_valid & (~valid_r | out_take);
  assign head_pop = fire & at_last;

  assign cnt_nxt   = fire ? (at_last ? '0 : cnt_r + 1'b1) : cnt_r;
  assign valid_nxt = fire | (valid_r & ~out_take);

  always_comb begin
    case (cnt_r)
      6'd0:  sel = next_hop_mac[47:40];
      6'd1:  sel = next_hop_mac[39:32];
      6'd2:  sel = next_hop_mac[31:24];
      6'd3:  sel = next_hop_mac[23:16];
      6'd4:  sel = next_hop_mac[15:8];
      6'd5:  sel = next_hop_mac[7:0];
      6'd6:  sel = local_mac[47:40];
      6'd7:  sel = local_mac[39:32];
      6'd8:  sel = local_mac[31:24];
      6'd9:  sel = local_mac[23:16];
      6'd10: sel = local_mac[15:8];
      6'd11: sel = local_mac[7:0];
      6'd12: sel = ETHERTYPE_IPV4[15:8];
      6'd13: sel = ETHERTYPE_IPV4[7:0];
      6'd14: sel = IP_VER_IHL;
      6'd16: sel = IP_TOTAL_LEN[15:8];
      6'd17: sel = IP_TOTAL_LEN[7:0];
      6'd22: sel = IP_TTL;
      6'd23: sel = IP_PROTO_ICMP;
      6'd24: sel = head_desc.ip_csum[15:8];
      6'd25: sel = head_desc.ip_csum[7:0];
      6'd26: sel = src_ip[31:24];
      6'd27: sel = src_ip[23:16];
      6'd28: sel = src_ip[15:8];
      6'd29: sel = src_ip[7:0];
      6'd30: sel = rq.dest_ip[31:24];
      6'd31: sel = rq.dest_ip[23:16];
      6'd32: sel = rq.dest_ip[15:8];
      6'd33: sel = rq.dest_ip[7:0];
      6'd34: sel = ICMP_ECHO_REQ;
      6'd35: sel = ICMP_CODE;
      6'd36: sel = head_desc.icmp_csum[15:8];
      6'd37: sel = head_desc.icmp_csum[7:0];
      6'd38: sel = rq.echo_id[15:8];
      6'd39: sel = rq.echo_id[7:0];
      6'd40: sel = rq.sequence_number[15:8];
      6'd41: sel = rq.sequence_number[7:0];
      // timestamp words go out least significant byte first
      6'd42: sel = rq.stamp_seconds[7:0];
      6'd43: sel = rq.stamp_seconds[15:8];
      6'd44: sel = rq.stamp_seconds[23:16];
      6'd45: sel = rq.stamp_seconds[31:24];
      6'd46: sel = rq.stamp_seconds[39:32];
      6'd47: sel = rq.stamp_seconds[47:40];
      6'd48: sel = rq.stamp_seconds[55:48];
      6'd49: sel = {1'b0, rq.stamp_seconds[62:56]};
      6'd50: sel = rq.stamp_micros[7:0];
      6'd51: sel = rq.stamp_micros[15:8];
      6'd52: sel = {4'b0, rq.stamp_micros[19:16]};
      default: sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r <= sel;
      last_r <= at_last;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

FILE: design/iefb_checker.sv
// Port-level checker for the frame builder, bound to the top level.
// Depends on iefb_pkg.
`default_nettype none

module iefb_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_push,
  input wire logic                          in_full,
  input wire logic                          out_empty,
  input wire logic                          out_pop,
  input wire logic [7:0]                    out_frame_byte,
  input wire logic                          out_last_byte
);
  import iefb_pkg::*;

  logic [BYTE_CNT_W-1:0] byte_cnt_r;
  logic [3:0]            pending_r;
  logic                  in_acc, out_acc, frame_done;

  assign in_acc     = in_push & ~in_full;
  assign out_acc    = out_pop & ~out_empty;
  assign frame_done = out_acc & out_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      pending_r  <= '0;
    end else begin
      if (out_acc) begin
        byte_cnt_r <= out_last_byte ? '0 : byte_cnt_r + 1'b1;
      end
      pending_r <= pending_r + {3'b0, in_acc} - {3'b0, frame_done};
    end
  end

  // Stalled output byte holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_frame_byte)))
    else $error("output byte changed while stalled");

  // Last marker exactly on the 58th byte of each frame
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (out_last_byte == (byte_cnt_r == LAST_BYTE_IDX)))
    else $error("last byte marker misplaced");

  // No bytes appear without an accepted request
  a_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r == '0) |-> out_empty)
    else $error("output without pending request");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("output not empty after reset");

endmodule

bind icmp_echo_request_frame_builder iefb_checker u_iefb_checker (.*);

`default_nettype wire

FILE: tb/sv/iefb_frame_checker.sv
// Frame checker for the ICMP echo request frame builder testbench.
// Watches the request, frame byte and register ports, predicts each frame and
// compares every byte. Depends on iefb_pkg.
`timescale 1ns / 100ps

module iefb_frame_checker
  import iefb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic                  in_full,
  input  wire logic [31:0]           in_dest_ip,
  input  wire logic [15:0]           in_echo_id,
  input  wire logic [15:0]           in_sequence_number,
  input  wire logic [62:0]           in_stamp_seconds,
  input  wire logic [19:0]           in_stamp_micros,
  input  wire logic                  out_empty,
  input  wire logic                  out_pop,
  input  wire logic [7:0]            out_frame_byte,
  input  wire logic                  out_last_byte,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         bytes_awaited,
  output int                         frames_done,
  output int                         bytes_done
);

  localparam int WIRE_LEN = 58;
  localparam int FRAME_W = 8 * WIRE_LEN;

  localparam logic [15:0] ETH_TYPE_IP4  = 16'h0800;
  localparam logic [7:0]  IP4_VER_IHL   = {4'd4, 4'd5};
  localparam logic [15:0] IP4_TOTAL_LEN = 16'd44;
  localparam logic [7:0]  IP4_TTL       = 8'd64;
  localparam logic [7:0]  IP4_PROTO     = 8'd1;
  localparam logic [7:0]  ECHO_TYPE     = 8'd8;
  localparam logic [7:0]  ECHO_CODE     = 8'd0;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } wire_byte_t;

  wire_byte_t frame_q[$];

  logic [47:0] src_mac = '0;
  logic [47:0] hop_mac = '0;
  logic [31:0] src_ip  = '0;

  int mismatches = 0;
  int frame_cnt  = 0;
  int byte_cnt   = 0;
  int awaited    = 0;

  assign fail_count    = mismatches;
  assign bytes_awaited = awaited;
  assign frames_done   = frame_cnt;
  assign bytes_done    = byte_cnt;

  // One's-complement sum of twelve 16-bit words, end-around carry, inverted
  function automatic logic [15:0] inet_checksum(input logic [191:0] words);
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < 12; i++) acc += words[191 - 16 * i -: 16];
    acc = (acc >> 16) + (acc & 32'hffff);
    acc = (acc >> 16) + (acc & 32'hffff);
    return ~acc[15:0];
  endfunction

  function automatic logic [63:0] byte_swap64(input logic [63:0] v);
    logic [63:0] r;
    for (int k = 0; k < 8; k++) r[63 - 8 * k -: 8] = v[8 * k +: 8];
    return r;
  endfunction

  function automatic logic [FRAME_W-1:0] build_frame(input logic [31:0] dest,
                                                     input logic [15:0] id,
                                                     input logic [15:0] seq,
                                                     input logic [62:0] secs,
                                                     input logic [19:0] usecs);
    logic [159:0] ip_hdr;
    logic [191:0] icmp_msg;
    ip_hdr = {IP4_VER_IHL, 8'h00, IP4_TOTAL_LEN, 32'h0, IP4_TTL, IP4_PROTO, 16'h0,
              src_ip, dest};
    // zero padding leaves the sum unchanged
    ip_hdr[79:64] = inet_checksum({ip_hdr, 32'h0});
    icmp_msg = {ECHO_TYPE, ECHO_CODE, 16'h0, id, seq, byte_swap64({1'b0, secs}),
                byte_swap64({44'h0, usecs})};
    icmp_msg[175:160] = inet_checksum(icmp_msg);
    return {hop_mac, src_mac, ETH_TYPE_IP4, ip_hdr, icmp_msg};
  endfunction

  always @(posedge clk) begin : watch
    logic [FRAME_W-1:0] frame;
    wire_byte_t want;
    if (!rst_n) begin
      src_mac = '0;
      hop_mac = '0;
      src_ip  = '0;
      frame_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOCAL_MAC:    src_mac = cfg_data;
          CFG_NEXT_HOP_MAC: hop_mac = cfg_data;
          CFG_LOCAL_IP:     src_ip  = cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        frame = build_frame(in_dest_ip, in_echo_id, in_sequence_number,
                            in_stamp_seconds, in_stamp_micros);
        for (int k = 0; k < WIRE_LEN; k++) begin
          want.frame_byte = frame[FRAME_W - 1 - 8 * k -: 8];
          want.last_byte  = (k == WIRE_LEN - 1);
          frame_q.push_back(want);
        end
      end
      if (out_pop && !out_empty) begin
        if (frame_q.size() == 0) begin
          mismatches++;
          $error("frame byte %02h popped with no frame pending", out_frame_byte);
        end else begin
          want = frame_q.pop_front();
          if (out_frame_byte !== want.frame_byte) begin
            mismatches++;
            $error("frame %0d byte %0d: frame_byte expected %02h, got %02h", frame_cnt,
                   byte_cnt % WIRE_LEN, want.frame_byte, out_frame_byte);
          end
          if (out_last_byte !== want.last_byte) begin
            mismatches++;
            $error("frame %0d byte %0d: last_byte expected %0b, got %0b", frame_cnt,
                   byte_cnt % WIRE_LEN, want.last_byte, out_last_byte);
          end
          byte_cnt++;
          if (want.last_byte) frame_cnt++;
        end
      end
    end
    awaited = frame_q.size();
  end

endmodule

FILE: tb/sv/tb_icmp_echo_request_frame_builder.sv
// Testbench top for the ICMP echo request frame builder: clock, reset, request
// and register stimulus, paced frame byte draining and the final verdict.
// Depends on iefb_pkg, iefb_frame_checker and the block itself.
`timescale 1ns / 100ps

module tb_icmp_echo_request_frame_builder;
  import iefb_pkg::*;

  // Index 3 decodes to no register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam int RESET_CYCLES    = 10;
  localparam int RAND_PHASES     = 4;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int CHOKE_CYCLES    = 600;   // long receiver hold-off, fills the block
  localparam int SETTLE_CYCLES   = 8;     // longer than the first-byte latency
  localparam int DRAIN_LIMIT     = 100000;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_push            = 1'b0;
  logic [31:0] in_dest_ip         = '0;
  logic [15:0] in_echo_id         = '0;
  logic [15:0] in_sequence_number = '0;
  logic [62:0] in_stamp_seconds   = '0;
  logic [19:0] in_stamp_micros    = '0;
  logic        out_pop            = 1'b0;
  logic        cfg_we             = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  wire logic       in_full;
  wire logic       out_empty;
  wire logic [7:0] out_frame_byte;
  wire logic       out_last_byte;

  int fail_count;
  int bytes_awaited;
  int frames_done;
  int bytes_done;

  int requests_sent  = 0;
  int settings_used  = 1;   // reset values count as the first setting
  bit drain_failed   = 1'b0;
  bit tx_burst       = 1'b0;   // sender runs back to back while set
  bit rx_burst       = 1'b0;   // receiver pops every cycle while set
  bit choke_pending  = 1'b0;   // asks the receiver for one long hold-off

  icmp_echo_request_frame_builder DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_dest_ip         (in_dest_ip),
    .in_echo_id         (in_echo_id),
    .in_sequence_number (in_sequence_number),
    .in_stamp_seconds   (in_stamp_seconds),
    .in_stamp_micros    (in_stamp_micros),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_frame_byte     (out_frame_byte),
    .out_last_byte      (out_last_byte),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  iefb_frame_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_dest_ip         (in_dest_ip),
    .in_echo_id         (in_echo_id),
    .in_sequence_number (in_sequence_number),
    .in_stamp_seconds   (in_stamp_seconds),
    .in_stamp_micros    (in_stamp_micros),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_frame_byte     (out_frame_byte),
    .out_last_byte      (out_last_byte),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .bytes_awaited      (bytes_awaited),
    .frames_done        (frames_done),
    .bytes_done         (bytes_done)
  );

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs; normal runs end far earlier
  initial begin : watchdog
    #20_000_000;
    $display("** icmp_echo_request_frame_builder: FAILED **");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random word, with all-zero and all-one values showing up now and then
  function automatic logic [63:0] field_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Offer one request and hold it until taken. push stays high across a
  // zero gap so the next item follows with no bubble.
  task automatic send_request(input logic [31:0] dest, input logic [15:0] id,
                              input logic [15:0] seq, input logic [62:0] secs,
                              input logic [19:0] usecs);
    int gap;
    in_push            <= 1'b1;
    in_dest_ip         <= dest;
    in_echo_id         <= id;
    in_sequence_number <= seq;
    in_stamp_seconds   <= secs;
    in_stamp_micros    <= usecs;
    do @(posedge clk); while (in_full);
    requests_sent++;
    gap = tx_burst ? 0 : idle_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [63:0] w0, w1, w2, w3, w4;
    w0 = field_word();
    w1 = field_word();
    w2 = field_word();
    w3 = field_word();
    w4 = field_word();
    send_request(w0[31:0], w1[15:0], w2[15:0], w3[62:0], w4[19:0]);
  endtask

  // Edge values, byte order probes and the zero-checksum corner
  task automatic send_directed();
    send_request('0, '0, '0, '0, '0);
    send_request('1, '1, '1, '1, '1);                   // micros far out of range
    send_request(32'h0102_0304, 16'h0102, 16'h0304, 63'd1, 20'd999999);
    send_request(32'hc0a8_0a01, 16'h1234, 16'h8000, 63'h0102_0304_0506_0708, 20'd1000000);
    // with all registers zero both sums fold to 0xffff, so both checksums are 0
    send_request(32'h7ad2_0000, 16'hf7ff, '0, '0, '0);
    send_request(32'haaaa_aaaa, 16'haaaa, 16'haaaa, {32'h2aaa_aaaa, 31'h2aaa_aaaa}, 20'haaaaa);
    send_request(32'h5555_5555, 16'h5555, 16'h5555, {32'h5555_5555, 31'h5555_5555}, 20'h55555);
    send_request('0, 16'h0001, 16'hffff, '1, '0);
  endtask

  // Close the phase: drop push, wait for every predicted byte, then let the
  // pipeline settle before any register write
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_push <= 1'b0;
    @(posedge clk);
    while (bytes_awaited != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (bytes_awaited != 0) begin
      drain_failed = 1'b1;
      $error("%0d frame bytes never arrived", bytes_awaited);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers, then a spare index that must be ignored.
  // Upper data bits on the address write check that only 32 bits are kept.
  task automatic load_registers(input logic [47:0] src_mac, input logic [47:0] hop_mac,
                                input logic [47:0] ip_data, input logic [47:0] spare);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOCAL_MAC;
    cfg_data  <= src_mac;
    @(posedge clk);
    cfg_index <= CFG_NEXT_HOP_MAC;
    cfg_data  <= hop_mac;
    @(posedge clk);
    cfg_index <= CFG_LOCAL_IP;
    cfg_data  <= ip_data;
    @(posedge clk);
    cfg_index <= CFG_IDX_SPARE;
    cfg_data  <= spare;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Receiver: pops with random pacing; one long hold-off on request
  initial begin : drain_side
    int gap;
    int popped;
    popped = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (choke_pending) begin
        choke_pending = 1'b0;
        out_pop <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      popped++;
      if (popped % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : idle_gap();
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [63:0] a, b, c, d;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items, first with the registers at their reset values,
    // then with every register at all ones
    send_directed();
    wait_idle();
    load_registers('1, '1, '1, {$urandom, $urandom});
    send_directed();
    wait_idle();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: load_registers('0, '0, {16'hffff, 32'h0}, '1);
        1: load_registers(48'haaaa_aaaa_aaaa, 48'h5555_5555_5555, 48'h5555_aaaa_aaaa, '0);
        default: begin
          a = {$urandom, $urandom};
          b = {$urandom, $urandom};
          c = {$urandom, $urandom};
          d = {$urandom, $urandom};
          load_registers(a[47:0], b[47:0], c[47:0], d[47:0]);
        end
      endcase
      // Hold the receiver off while requests keep coming, so the queue fills
      // and in_full has to push back
      if (phase == 1) begin
        choke_pending = 1'b1;
        tx_burst      = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 20 == 19) tx_burst = ($urandom_range(0, 3) == 0);
        send_random();
      end
      wait_idle();
    end

    $display("Sent %0d echo requests under %0d register settings, one %0d-cycle hold-off;",
             requests_sent, settings_used, CHOKE_CYCLES);
    $display("checked %0d frames, %0d bytes, against the predicted frames.",
             frames_done, bytes_done);
    if (fail_count == 0 && !drain_failed) begin
      $display("** icmp_echo_request_frame_builder: PASSED **");
    end else begin
      $display("** icmp_echo_request_frame_builder: FAILED **");
    end
    $finish;
  end

endmodule
